[design/kruskal_maze_wall_merger_macros.svh]
// Assertion macros shared by the wall merger RTL.
`ifndef KRUSKAL_MAZE_WALL_MERGER_MACROS_SVH
`define KRUSKAL_MAZE_WALL_MERGER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KMW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KMW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/kmw_pkg.sv]
// Shared types and constants for the maze wall merger.
`timescale 1ns / 1ps

package kmw_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int CODE_W     = 13;
	localparam int ROW_W      = 6;
	localparam int SIDE_W     = 7;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 1'd0,
		REG_GRID_HEIGHT = 1'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OUT_CARVED    = 2'd0,
		OUT_BORDER    = 2'd1,
		OUT_CONNECTED = 2'd2,
		OUT_RANGE     = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_CHECK,
		ST_DIV,
		ST_BORDER,
		ST_FIND_A,
		ST_FIND_B,
		ST_DONE
	} state_t;

endpackage

[design/kmw_channels.sv]
// Valid/ready channel interfaces: wall requests, results and register writes.
`timescale 1ns / 1ps

interface kmw_wall_if import kmw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] wall_code;
	logic              new_maze;

	modport source (output valid, output wall_code, output new_maze, input ready);
	modport sink (input valid, input wall_code, input new_maze, output ready);
endinterface

interface kmw_result_if import kmw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] cell_row;
	logic [ROW_W-1:0] cell_col;
	logic             wall_side;
	logic [1:0]       outcome;

	modport source (output valid, output cell_row, output cell_col, output wall_side,
		output outcome, input ready);
	modport sink (input valid, input cell_row, input cell_col, input wall_side,
		input outcome, output ready);
endinterface

interface kmw_cfg_if import kmw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIDE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/kruskal_maze_wall_merger.sv]
// Randomized Kruskal maze step: wall decode plus union-find merge over a parent RAM.
`timescale 1ns / 1ps
`include "kruskal_maze_wall_merger_macros.svh"

// One wall request at a time. After reset, and before any request that has new_maze
// set, the block sweeps the 4096-entry parent RAM (entry i <- i), one entry per cycle,
// and takes no request during the sweep; register writes are always taken.
// A request then runs a range check; an in-range one runs the divide and a border
// check, and an interior wall then walks from the cell and from its neighbor up to
// their set roots. The root walks dominate: each link is one read of the parent
// RAM's single read port, whose data addresses the next read. Row and column come
// from a 6-step shift-subtract divider. A finished result sits in an output register,
// so the next request is taken while it waits to be read.
module kruskal_maze_wall_merger import kmw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	kmw_wall_if.sink     walls,
	kmw_result_if.source results,
	kmw_cfg_if.sink      cfg
);

	localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_COUNT - 1);
	localparam int DIV_CNT_W = $clog2(ROW_W);

	// parent RAM, one read port with registered data, one write port
	logic [CELL_W-1:0] set_parent_mem [CELL_COUNT];
	logic [CELL_W-1:0] rd_data_s1;
	logic              mem_re;
	logic [CELL_W-1:0] mem_raddr;
	logic              mem_we;
	logic [CELL_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;

	state_t state_q, state_d;

	// registers and config
	logic [SIDE_W-1:0] grid_width_q, grid_height_q;
	logic [SIDE_W-1:0] w_eff, h_eff;
	logic [13:0]       grid_area;

	// control
	logic [CELL_W-1:0] cnt_q;
	logic              item_q;
	logic              out_valid_q;
	logic              in_accept;
	logic              out_load;
	logic              out_of_range;
	logic              is_border;
	logic              walk_done;

	// per-request working registers
	logic [CELL_W-1:0]    cell_idx_q;
	logic                 side_q;
	logic [SIDE_W-1:0]    w_q;
	logic [CELL_W-1:0]    rem_q;
	logic [ROW_W-1:0]     row_q;
	logic [ROW_W-1:0]     col_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CELL_W-1:0]    div_shift;
	logic [CELL_W-1:0]    cur_q;
	logic [CELL_W-1:0]    nb_q;
	logic [CELL_W-1:0]    ra_q;
	outcome_t             outcome_q;

	// result register
	logic [ROW_W-1:0] res_row_q, res_col_q;
	logic             res_side_q;
	outcome_t         res_outcome_q;

	// 0 acts as 1, anything past MAX_SIDE acts as MAX_SIDE
	always_comb begin
		w_eff = grid_width_q;
		if (grid_width_q == '0) begin
			w_eff = SIDE_W'(1);
		end else if (grid_width_q > SIDE_W'(MAX_SIDE)) begin
			w_eff = SIDE_W'(MAX_SIDE);
		end
		h_eff = grid_height_q;
		if (grid_height_q == '0) begin
			h_eff = SIDE_W'(1);
		end else if (grid_height_q > SIDE_W'(MAX_SIDE)) begin
			h_eff = SIDE_W'(MAX_SIDE);
		end
	end

	assign grid_area    = 14'(w_eff) * 14'(h_eff);
	assign out_of_range = 14'(cell_idx_q) >= grid_area;
	assign div_shift    = CELL_W'(w_q) << div_cnt_q;
	assign is_border    = (!side_q && row_q == '0) || (side_q && rem_q == '0);
	// root found, or the walk hit its step cap; either way the root is the data read
	assign walk_done    = (rd_data_s1 == cur_q) || (cnt_q == CELL_LAST);
	assign in_accept    = walls.valid && walls.ready;

	assign cfg.ready         = 1'b1;
	assign results.valid     = out_valid_q;
	assign results.cell_row  = res_row_q;
	assign results.cell_col  = res_col_q;
	assign results.wall_side = res_side_q;
	assign results.outcome   = res_outcome_q;

	// memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			set_parent_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_s1 <= set_parent_mem[mem_raddr];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM strobes, handshake
	always_comb begin
		state_d     = state_q;
		walls.ready = 1'b0;
		mem_re      = 1'b0;
		mem_raddr   = rd_data_s1;
		mem_we      = 1'b0;
		mem_waddr   = ra_q;
		mem_wdata   = rd_data_s1;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				walls.ready = 1'b1;
				if (walls.valid) begin
					state_d = walls.new_maze ? ST_CLEAR : ST_CHECK;
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = cnt_q;
				if (cnt_q == CELL_LAST) begin
					state_d = item_q ? ST_CHECK : ST_IDLE;
				end
			end
			ST_CHECK: begin
				state_d = out_of_range ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_BORDER;
				end
			end
			ST_BORDER: begin
				if (is_border) begin
					state_d = ST_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = cell_idx_q;
					state_d   = ST_FIND_A;
				end
			end
			ST_FIND_A: begin
				mem_re = 1'b1;
				if (walk_done) begin
					mem_raddr = nb_q;
					state_d   = ST_FIND_B;
				end
			end
			ST_FIND_B: begin
				if (walk_done) begin
					// link the cell's root under the neighbor's root
					mem_we  = rd_data_s1 != ra_q;
					state_d = ST_DONE;
				end else begin
					mem_re = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			item_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			grid_width_q  <= SIDE_W'(64);
			grid_height_q <= SIDE_W'(64);
		end else begin
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					REG_GRID_WIDTH:  grid_width_q  <= cfg.data;
					REG_GRID_HEIGHT: grid_height_q <= cfg.data;
					default: ;
				endcase
			end
			if (in_accept) begin
				item_q <= 1'b1;
			end else if (out_load) begin
				item_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			// sweep address during a clear, step count during a root walk
			case (state_q)
				ST_IDLE:   cnt_q <= '0;
				ST_CLEAR:  cnt_q <= cnt_q + 1'b1;
				ST_BORDER: cnt_q <= '0;
				ST_FIND_A: cnt_q <= walk_done ? '0 : cnt_q + 1'b1;
				ST_FIND_B: cnt_q <= cnt_q + 1'b1;
				default:   cnt_q <= cnt_q;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cell_idx_q <= walls.wall_code[CODE_W-1:1];
			side_q     <= walls.wall_code[0];
		end
		case (state_q)
			ST_CHECK: begin
				w_q       <= w_eff;
				rem_q     <= cell_idx_q;
				row_q     <= '0;
				div_cnt_q <= DIV_CNT_W'(ROW_W - 1);
				col_q     <= '0;
				outcome_q <= OUT_RANGE;
			end
			ST_DIV: begin
				// restoring divide, one quotient bit per cycle
				if (rem_q >= div_shift) begin
					rem_q <= rem_q - div_shift;
					row_q <= row_q | (ROW_W'(1) << div_cnt_q);
				end
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			ST_BORDER: begin
				col_q     <= rem_q[ROW_W-1:0];
				nb_q      <= side_q ? cell_idx_q - 1'b1 : cell_idx_q - CELL_W'(w_q);
				cur_q     <= cell_idx_q;
				outcome_q <= OUT_BORDER;
			end
			ST_FIND_A: begin
				if (walk_done) begin
					ra_q  <= rd_data_s1;
					cur_q <= nb_q;
				end else begin
					cur_q <= rd_data_s1;
				end
			end
			ST_FIND_B: begin
				if (walk_done) begin
					outcome_q <= (rd_data_s1 == ra_q) ? OUT_CONNECTED : OUT_CARVED;
				end else begin
					cur_q <= rd_data_s1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			res_row_q     <= row_q;
			res_col_q     <= col_q;
			res_side_q    <= side_q;
			res_outcome_q <= outcome_q;
		end
	end

	// a merge never links a root to itself
	`KMW_ASSERT_NOW(a_no_self_link, mem_we && state_q == ST_FIND_B, mem_waddr != mem_wdata, "self link")
	// divider left a valid quotient and remainder
	`KMW_ASSERT_NOW(a_div_exact, state_q == ST_BORDER, (rem_q < CELL_W'(w_q)) && ((CELL_W'(row_q) * CELL_W'(w_q) + rem_q) == cell_idx_q), "bad row/col split")
	// out-of-range results report row and column zero
	`KMW_ASSERT_NOW(a_range_zero, state_q == ST_DONE && outcome_q == OUT_RANGE, row_q == '0 && col_q == '0, "range result not zeroed")
	// an accepted request starts work at once
	`KMW_ASSERT_NEXT(a_accept_start, in_accept, state_q == ST_CHECK || state_q == ST_CLEAR, "request not started")

endmodule
